// ----- hw/rtl/bmx_pkg.sv -----
// Shared types, register codes and constants of the binary cross morphology filter.
package bmx_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_POS_W   = 10;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_ERODE  = 2'd0,
        MODE_DILATE = 2'd1,
        MODE_PASS   = 2'd2
    } mode_t;

    // Which of the up to three results an item causes, with their filtered pixels.
    typedef struct packed {
        logic has_a;
        logic has_b;
        logic has_c;
        logic pix_a;
        logic pix_b;
        logic pix_c;
    } result_flags_t;

    localparam int FLAGS_W = $bits(result_flags_t);

    // Bits needed to index positions 0 .. n-1, at least one.
    function automatic int pos_width(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

// ----- hw/rtl/bmx_front.sv -----
// Front end: position tracking, line stores, neighbourhood window and result classification.
module bmx_front
    import bmx_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          mode,
    input  logic [CFG_DATA_W-1:0]               image_width,
    input  logic [CFG_DATA_W-1:0]               image_height,
    input  logic                                push,
    output logic                                full,
    input  logic                                pixel_in,
    output logic                                q_push,
    input  logic                                q_full,
    output logic [pos_width(MAX_HEIGHT)-1:0]    q_row,
    output logic [pos_width(MAX_WIDTH)-1:0]     q_col,
    output result_flags_t                       q_flags
);

    localparam int COL_W = pos_width(MAX_WIDTH);
    localparam int ROW_W = pos_width(MAX_HEIGHT);
    localparam int CW    = COL_W + 1;
    localparam int RW    = ROW_W + 1;
    localparam int MEM_DEPTH = 2 ** (COL_W + 1);

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic has_c;
        logic r_zero;
        logic pr_zero;
        logic c_zero;
        logic c_right;
        logic cc_zero;
        logic w_one;
    } item_class_t;

    function automatic logic combine(input logic [1:0] m, input logic cv, input logic uv,
                                     input logic dv, input logic lv, input logic rv);
        logic res;
        case (m)
            MODE_ERODE:  res = cv & uv & dv & lv & rv;
            MODE_DILATE: res = cv | uv | dv | lv | rv;
            default:     res = cv;
        endcase
        return res;
    endfunction

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;
    logic [31:0]      wv, hv;
    logic             restart, accept, c_last, r_last;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    item_class_t      cls;

    logic             mem [MEM_DEPTH];
    logic [COL_W:0]   addr_a, addr_b;
    logic             rd_a_reg, rd_b_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    item_class_t      s1_cls_reg;
    logic             s1_any, s1_go;

    logic             win_c_reg, win_l_reg, cur1_reg, cur2_reg;
    logic             a_cen, a_up, a_lf, a_rt, b_cen, b_up, b_lf, c_up, c_lf;

    // Sizes out of range are taken to the nearest legal value.
    always_comb
    begin
        wv = 32'(image_width);
        hv = 32'(image_height);
        if (wv == 32'd0)
            w_eff = CW'(1);
        else if (wv > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(wv);
        if (hv == 32'd0)
            h_eff = RW'(1);
        else if (hv > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(hv);
    end

    assign s1_any = s1_cls_reg.has_a | s1_cls_reg.has_b | s1_cls_reg.has_c;
    assign s1_go  = s1_valid_reg && (!s1_any || !q_full);
    assign full   = s1_valid_reg && !s1_go;
    assign accept = push && !full;

    always_comb
    begin
        restart = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_eff);
        c       = restart ? '0 : col_reg;
        r       = restart ? '0 : row_reg;
        c_last  = ({1'b0, c} == w_eff - CW'(1));
        r_last  = ({1'b0, r} == h_eff - RW'(1));

        cls.has_a   = (r != '0);
        cls.has_b   = r_last && (c != '0);
        cls.has_c   = r_last && c_last;
        cls.r_zero  = (r == '0);
        cls.pr_zero = (r == ROW_W'(1));
        cls.c_zero  = (c == '0);
        cls.c_right = c_last;
        cls.cc_zero = (c == COL_W'(1));
        cls.w_one   = (w_eff == CW'(1));

        if (c_last)
        begin
            col_next = '0;
            row_next = r_last ? '0 : r + ROW_W'(1);
        end
        else
        begin
            col_next = c + COL_W'(1);
            row_next = r;
        end

        // At the end of a row the right-hand read is not needed, so it fetches the
        // first pixel of this row, which becomes the centre of the next row's start.
        addr_a = c_last ? {r[0], COL_W'(0)} : {~r[0], c + COL_W'(1)};
        addr_b = {r[0], c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
    end

    // Line stores: the read at the write address returns the row two above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg     <= mem[addr_a];
            rd_b_reg     <= mem[addr_b];
            mem[addr_b]  <= pixel_in;
            s1_pix_reg   <= pixel_in;
            s1_col_reg   <= c;
            s1_row_reg   <= r;
            s1_cls_reg   <= cls;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            win_l_reg <= win_c_reg;
            win_c_reg <= (s1_cls_reg.c_right && s1_cls_reg.w_one) ? s1_pix_reg : rd_a_reg;
            cur2_reg  <= cur1_reg;
            cur1_reg  <= s1_pix_reg;
        end
    end

    always_comb
    begin
        a_cen = win_c_reg;
        a_up  = s1_cls_reg.pr_zero ? a_cen : rd_b_reg;
        a_lf  = s1_cls_reg.c_zero  ? a_cen : win_l_reg;
        a_rt  = s1_cls_reg.c_right ? a_cen : rd_a_reg;
        b_cen = cur1_reg;
        b_up  = s1_cls_reg.r_zero  ? b_cen : win_l_reg;
        b_lf  = s1_cls_reg.cc_zero ? b_cen : cur2_reg;
        c_up  = s1_cls_reg.r_zero  ? s1_pix_reg : win_c_reg;
        c_lf  = s1_cls_reg.c_zero  ? s1_pix_reg : cur1_reg;

        q_flags.has_a = s1_cls_reg.has_a;
        q_flags.has_b = s1_cls_reg.has_b;
        q_flags.has_c = s1_cls_reg.has_c;
        q_flags.pix_a = combine(mode, a_cen, a_up, s1_pix_reg, a_lf, a_rt);
        q_flags.pix_b = combine(mode, b_cen, b_up, b_cen, b_lf, s1_pix_reg);
        q_flags.pix_c = combine(mode, s1_pix_reg, c_up, s1_pix_reg, c_lf, s1_pix_reg);
    end

    assign q_push = s1_valid_reg && s1_any && !q_full;
    assign q_row  = s1_row_reg;
    assign q_col  = s1_col_reg;

endmodule

// ----- hw/rtl/bmx_queue.sv -----
// Short first-in first-out queue between the front end and the result sequencer.
module bmx_queue
    import bmx_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PTR_W = pos_width(DEPTH);

    logic [DATA_W-1:0] store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- hw/rtl/bmx_back.sv -----
// Result sequencer: turns each queued item into its ordered results on the output side.
module bmx_back
    import bmx_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  logic [pos_width(MAX_HEIGHT)-1:0] q_row,
    input  logic [pos_width(MAX_WIDTH)-1:0]  q_col,
    input  result_flags_t                    q_flags,
    output logic                             empty,
    input  logic                             pop,
    output logic                             pixel_out,
    output logic [OUT_POS_W-1:0]             out_row,
    output logic [OUT_POS_W-1:0]             out_col,
    output logic                             last_of_frame,
    output logic                             last_of_item
);

    localparam int COL_W = pos_width(MAX_WIDTH);
    localparam int ROW_W = pos_width(MAX_HEIGHT);

    result_flags_t    flags_reg, flags_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             taken, load;

    assign empty = !(flags_reg.has_a || flags_reg.has_b || flags_reg.has_c);
    assign taken = pop && !empty;
    assign load  = q_valid && (empty || (taken && last_of_item));
    assign q_pop = load;

    // Results leave in the order: row above, left neighbour on the last row, own pixel.
    always_comb
    begin
        if (flags_reg.has_a)
        begin
            pixel_out     = flags_reg.pix_a;
            out_row       = OUT_POS_W'(row_reg - ROW_W'(1));
            out_col       = OUT_POS_W'(col_reg);
            last_of_frame = 1'b0;
            last_of_item  = !flags_reg.has_b && !flags_reg.has_c;
        end
        else if (flags_reg.has_b)
        begin
            pixel_out     = flags_reg.pix_b;
            out_row       = OUT_POS_W'(row_reg);
            out_col       = OUT_POS_W'(col_reg - COL_W'(1));
            last_of_frame = 1'b0;
            last_of_item  = !flags_reg.has_c;
        end
        else
        begin
            pixel_out     = flags_reg.pix_c;
            out_row       = OUT_POS_W'(row_reg);
            out_col       = OUT_POS_W'(col_reg);
            last_of_frame = 1'b1;
            last_of_item  = 1'b1;
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (load)
            flags_next = q_flags;
        else if (taken)
        begin
            if (flags_reg.has_a)
                flags_next.has_a = 1'b0;
            else if (flags_reg.has_b)
                flags_next.has_b = 1'b0;
            else
                flags_next.has_c = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= q_row;
            col_reg <= q_col;
        end
    end

endmodule

// ----- hw/rtl/binary_morphology_cross_filter.sv -----
// Top level of the binary cross morphology filter: configuration registers and block wiring.
//
// Binary erosion, dilation or pass-through over the centre pixel and its four
// cross neighbours, for an image streamed in raster order, one pixel per request
// (1 is black). Neighbours outside the image take the centre value. The result for
// pixel (r-1,c) leaves when pixel (r,c) arrives; on the last row the result for
// (last,c-1) follows it, and the final pixel's own result closes the frame with
// last_of_frame set. last_of_item marks the last result caused by each input
// request; pixels of the first row cause no result unless the image is one row
// high. The input accepts one pixel per clock unless the front end stalls on a
// full queue; a pixel's first result passes the front end's classification stage
// and the queue and is loaded into the result sequencer. The single result port
// sets the sustained rate: ordinary rows run at one pixel per clock while the
// receiver takes every result, and last-row pixels of an image of two or more
// rows carry up to three results, behind a four-entry queue between the front end
// and the result sequencer. Two banks of MAX_WIDTH one-bit line stores hold the
// previous rows and need no clearing after reset. The user must write mode, width
// and height through the configuration port only while the filter is idle; the
// block does not enforce this. Sizes of zero count as one, sizes above the
// maximum saturate, and a position outside a new size restarts the frame.
module binary_morphology_cross_filter
    import bmx_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   pixel_in,
    output logic                   empty,
    input  logic                   pop,
    output logic                   pixel_out,
    output logic [OUT_POS_W-1:0]   out_row,
    output logic [OUT_POS_W-1:0]   out_col,
    output logic                   last_of_frame,
    output logic                   last_of_item
);

    localparam int COL_W   = pos_width(MAX_WIDTH);
    localparam int ROW_W   = pos_width(MAX_HEIGHT);
    localparam int ENTRY_W = ROW_W + COL_W + FLAGS_W;

    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    logic                  q_push, q_full, q_empty, q_pop;
    logic [ROW_W-1:0]      f_row, b_row;
    logic [COL_W-1:0]      f_col, b_col;
    result_flags_t         f_flags, b_flags;
    logic [ENTRY_W-1:0]    q_wdata, q_rdata;

    // Configuration registers; an index beyond the list writes nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ERODE;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // The front end accepts pixels, reads the line stores and works out each
    // pixel's results; it stalls only when the queue has no room.
    bmx_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (push),
        .full         (full),
        .pixel_in     (pixel_in),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_row        (f_row),
        .q_col        (f_col),
        .q_flags      (f_flags)
    );

    assign q_wdata = {f_row, f_col, f_flags};

    bmx_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (DEF_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_row, b_col, b_flags} = q_rdata;

    // The sequencer presents one result at a time and fetches the next item as
    // the last result of the current one is taken.
    bmx_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (!q_empty),
        .q_pop         (q_pop),
        .q_row         (b_row),
        .q_col         (b_col),
        .q_flags       (b_flags),
        .empty         (empty),
        .pop           (pop),
        .pixel_out     (pixel_out),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame),
        .last_of_item  (last_of_item)
    );

`ifndef ASSERT_OFF
    // The frame's final result always closes its own request.
    a_frame_end_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_frame) |-> last_of_item)
        else $error("last_of_frame without last_of_item");

    // The front end never pushes an item into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // A waiting queued item reaches the output by the next cycle when it is idle.
    a_output_refills: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !q_empty) |=> !empty)
        else $error("result port stayed empty with items queued");

    // The sequencer only fetches from a queue that holds an item.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");
`endif

endmodule

// ----- bench/tb_binary_morphology_cross_filter.sv -----
// Self-checking testbench for the binary cross morphology filter.
module tb_binary_morphology_cross_filter;
    import bmx_pkg::*;

    // Line store geometry and the clamping limits of the sizes.
    localparam int unsigned MAX_W = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H = DEF_MAX_HEIGHT;

    // The unused mode code behaves like pass-through.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Cycles granted after the last expected result before the filter counts as
    // idle. Pixels of the first row cause no result and may still be in flight.
    localparam int IDLE_WAIT = 16;

    // Cycles without any accepted request before the run is declared hung. The
    // longest correct pause is a drain wait or a receiver stall, both far shorter.
    localparam int HANG_LIMIT = 4000;

    // Random pixels to send after the directed part and the long stretches.
    localparam int RANDOM_ITEMS = 120;

    // Pixels sent along a saturated row and along a saturated column.
    localparam int LONG_STRETCH = 16;

    // Cap on printed mismatch lines; the count goes on regardless.
    localparam int MAX_PRINTS = 40;

    // One filtered pixel as it leaves the block.
    typedef struct packed {
        logic                 pix;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 lof;
        logic                 loi;
    } pix_result_t;

    // A row of the directed script either writes a register or sends a pixel.
    typedef enum bit {
        STEP_CFG,
        STEP_PIXEL
    } step_kind_t;

    typedef struct {
        step_kind_t      kind;
        cfg_index_t      idx;
        logic [10:0]     data;
        logic            pix;
        bit              typed;
        pix_result_t     want;
    } script_row_t;

    localparam pix_result_t NO_RESULT   = '0;
    // A one-pixel image: the single result is both the last of the frame and
    // the last caused by its request, at row 0 and column 0.
    localparam pix_result_t ONLY_BLACK  = '{1'b1, 10'd0, 10'd0, 1'b1, 1'b1};
    localparam pix_result_t ONLY_WHITE  = '{1'b0, 10'd0, 10'd0, 1'b1, 1'b1};

    localparam int SCRIPT_LEN = 32;

    // Directed part. It opens on the reset sizes, then shrinks the image to a
    // single pixel in the middle of a row, which forces a frame restart and
    // exercises the zero-size clamp. The one-pixel image is run in every mode,
    // the unused code among them, with the results typed in. A 3x3 erosion and
    // a 2x2 dilation follow and are checked against the predictor.
    script_row_t script [SCRIPT_LEN] = '{
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_WIDTH,  11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_HEIGHT, 11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b1, ONLY_BLACK},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b1, ONLY_WHITE},
        '{STEP_CFG,   CFG_MODE,   11'(MODE_DILATE), 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b1, ONLY_BLACK},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b1, ONLY_WHITE},
        '{STEP_CFG,   CFG_MODE,   11'(MODE_SPARE), 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b1, ONLY_BLACK},
        '{STEP_CFG,   CFG_MODE,   11'(MODE_PASS), 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b1, ONLY_WHITE},
        '{STEP_CFG,   CFG_MODE,   11'(MODE_ERODE), 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_WIDTH,  11'd3, 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_HEIGHT, 11'd3, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_MODE,   11'(MODE_DILATE), 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_WIDTH,  11'd2, 1'b0, 1'b0, NO_RESULT},
        '{STEP_CFG,   CFG_HEIGHT, 11'd2, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b0, 1'b0, NO_RESULT},
        '{STEP_PIXEL, CFG_MODE,   11'd0, 1'b1, 1'b0, NO_RESULT}
    };

    // Every input of the filter starts at a known value.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   push      = 1'b0;
    logic                   full;
    logic                   pixel_in  = 1'b0;
    logic                   empty;
    logic                   pop       = 1'b0;
    logic                   pixel_out;
    logic [OUT_POS_W-1:0]   out_row;
    logic [OUT_POS_W-1:0]   out_col;
    logic                   last_of_frame;
    logic                   last_of_item;

    // Predictor state: the two line banks, the position of the next pixel and
    // a shadow copy of the registers, all at their reset values.
    bit              line_buf [0:2*MAX_W-1];
    int unsigned     row_pos  = 0;
    int unsigned     col_pos  = 0;
    logic [1:0]      mode_r   = MODE_ERODE;
    logic [10:0]     wid_r    = WIDTH_RESET;
    logic [10:0]     hei_r    = HEIGHT_RESET;

    pix_result_t     fresh_pixels   [$];  // results of the request just taken
    pix_result_t     awaited_pixels [$];  // results still to leave the filter

    // A typed-in expectation replaces the predicted one for the next request.
    bit              typed_on   = 1'b0;
    pix_result_t     typed_want = NO_RESULT;

    int              mismatches  = 0;
    int              idle_cycles = 0;
    int              burst_left  = 0;

    binary_morphology_cross_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .pixel_in      (pixel_in),
        .empty         (empty),
        .pop           (pop),
        .pixel_out     (pixel_out),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame),
        .last_of_item  (last_of_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A size of zero counts as one and a size above the store saturates.
    function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned cap);
        if (v == 11'd0)
        begin
            return 1;
        end
        if (v > cap)
        begin
            return cap;
        end
        return 32'(v);
    endfunction

    function automatic bit line_at(input int unsigned row, input int unsigned col);
        return line_buf[(row & 1) * MAX_W + (col % MAX_W)];
    endfunction

    // Erosion is the AND of the cross, dilation the OR; every other code,
    // the unused one included, hands the centre through.
    function automatic logic cross_combine(input logic c, input logic u, input logic d,
                                           input logic l, input logic r);
        case (mode_r)
            MODE_ERODE:  return c & u & d & l & r;
            MODE_DILATE: return c | u | d | l | r;
            default:     return c;
        endcase
    endfunction

    function automatic pix_result_t make_result(input logic p, input int unsigned row,
                                                input int unsigned col, input logic lof);
        pix_result_t res;
        res.pix = p;
        res.row = OUT_POS_W'(row);
        res.col = OUT_POS_W'(col);
        res.lof = lof;
        res.loi = 1'b0;
        return res;
    endfunction

    // Works out the filtered pixels released by one incoming pixel and moves
    // the predictor on by one position. Results go to fresh_pixels.
    function automatic void filter_step(input logic p);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned pr;
        int unsigned cc;
        logic        cen;
        logic        up;
        logic        lf;
        logic        rt;
        fresh_pixels.delete();
        w = eff_size(wid_r, MAX_W);
        h = eff_size(hei_r, MAX_H);
        // A position left outside the image by a size change restarts the frame.
        if (col_pos >= w || row_pos >= h)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        // The pixel above is now complete, since its lower neighbour has arrived.
        if (r >= 1)
        begin
            pr  = r - 1;
            cen = line_at(pr, c);
            up  = (pr == 0) ? cen : line_at(pr - 1, c);
            lf  = (c == 0) ? cen : line_at(pr, c - 1);
            rt  = (c == w - 1) ? cen : line_at(pr, c + 1);
            fresh_pixels.push_back(make_result(cross_combine(cen, up, p, lf, rt), pr, c, 1'b0));
        end
        // On the bottom row the left neighbour is complete once its right one is here.
        if (r == h - 1 && c >= 1)
        begin
            cc  = c - 1;
            cen = line_at(r, cc);
            up  = (r == 0) ? cen : line_at(r - 1, cc);
            lf  = (cc == 0) ? cen : line_at(r, cc - 1);
            fresh_pixels.push_back(make_result(cross_combine(cen, up, cen, lf, p), r, cc, 1'b0));
        end
        // The bottom-right pixel closes the frame with its own result.
        if (r == h - 1 && c == w - 1)
        begin
            up = (r == 0) ? p : line_at(r - 1, c);
            lf = (c == 0) ? p : line_at(r, c - 1);
            fresh_pixels.push_back(make_result(cross_combine(p, up, p, lf, p), r, c, 1'b1));
        end
        if (fresh_pixels.size() > 0)
        begin
            fresh_pixels[fresh_pixels.size() - 1].loi = 1'b1;
        end
        line_buf[(r & 1) * MAX_W + (c % MAX_W)] = p;
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Everything is observed at the rising edge, on the values that held just
    // before it: register writes update the shadow copy, an accepted pixel
    // request feeds the predictor, and an accepted result request is checked
    // field by field against the oldest expectation.
    always @(posedge clk)
    begin : observe
        pix_result_t got;
        pix_result_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_r = cfg_data[1:0];
                    CFG_WIDTH:  wid_r  = cfg_data;
                    CFG_HEIGHT: hei_r  = cfg_data;
                    default:    ;
                endcase
            end
            if (push && !full)
            begin
                filter_step(pixel_in);
                if (typed_on)
                begin
                    awaited_pixels.push_back(typed_want);
                end
                else
                begin
                    foreach (fresh_pixels[k])
                    begin
                        awaited_pixels.push_back(fresh_pixels[k]);
                    end
                end
            end
            if (pop && !empty)
            begin
                got = '{pixel_out, out_row, out_col, last_of_frame, last_of_item};
                if (awaited_pixels.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result at (%0d,%0d)", out_row, out_col));
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    if (got.pix !== want.pix)
                    begin
                        flag_mismatch($sformatf("pixel_out %b, expected %b at (%0d,%0d)",
                                                got.pix, want.pix, want.row, want.col));
                    end
                    if (got.row !== want.row)
                    begin
                        flag_mismatch($sformatf("out_row %0d, expected %0d",
                                                got.row, want.row));
                    end
                    if (got.col !== want.col)
                    begin
                        flag_mismatch($sformatf("out_col %0d, expected %0d",
                                                got.col, want.col));
                    end
                    if (got.lof !== want.lof)
                    begin
                        flag_mismatch($sformatf("last_of_frame %b, expected %b at (%0d,%0d)",
                                                got.lof, want.lof, want.row, want.col));
                    end
                    if (got.loi !== want.loi)
                    begin
                        flag_mismatch($sformatf("last_of_item %b, expected %b at (%0d,%0d)",
                                                got.loi, want.loi, want.row, want.col));
                    end
                end
            end
        end
    end

    // The receiver switches between styles of its own: always ready, a coin
    // toss, a regular one-in-four stall, and long mostly-stalled stretches.
    int pop_style = 0;
    int style_left = 0;
    int pop_tick = 0;

    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            pop_style  = $urandom_range(0, 3);
            style_left = $urandom_range(20, 200);
        end
        else
        begin
            style_left--;
        end
        pop_tick++;
        case (pop_style)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (pop_tick % 4 != 3);
            default: pop <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // Hang detection: any accepted request on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit at_frame_start();
        return row_pos == 0 && col_pos == 0;
    endfunction

    // Offers one pixel request from a falling edge and holds it until taken.
    // The sender then either carries on within its burst or lowers push for a
    // random gap, so that pauses land on every phase of the filter's work.
    task automatic send_pixel(input logic p, input bit typed, input pix_result_t want);
        typed_on   = typed;
        typed_want = want;
        push     <= 1'b1;
        pixel_in <= p;
        do
        begin
            @(posedge clk);
        end
        while (full);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            push     <= 1'b0;
            pixel_in <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 12);
        end
    endtask

    // Black pixels appear with the given percentage.
    task automatic send_random(input int black_pct);
        send_pixel(1'($urandom_range(0, 99) < black_pct), 1'b0, NO_RESULT);
    endtask

    // Waits until every expected result has left, then lets the pixels that
    // cause no result run out of the pipeline before a register write.
    task automatic settle_filter();
        push <= 1'b0;
        while (awaited_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [10:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Completes the running frame so that the next one starts cleanly, then
    // sets all three registers. Widening the image is only safe from here,
    // since a wider row would otherwise read line store entries never filled.
    task automatic start_frame(input logic [10:0] m, input logic [10:0] w, input logic [10:0] h,
                               input int black_pct);
        while (!at_frame_start())
        begin
            send_random(black_pct);
        end
        settle_filter();
        write_reg(CFG_MODE, m);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    initial
    begin : stimulus
        int          random_items;
        int          black_pct;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        random_items = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == STEP_CFG)
            begin
                settle_filter();
                write_reg(script[i].idx, script[i].data);
            end
            else
            begin
                send_pixel(script[i].pix, script[i].typed, script[i].want);
            end
        end

        // The largest sizes, each reached through a register value that
        // saturates: a stretch along a one-row image of full width, then along
        // a one-column image of full height. A smaller size ends each stretch,
        // and the next pixel restarts the frame.
        start_frame(11'($urandom_range(0, 3)), 11'd2047, 11'd1, 50);
        repeat (LONG_STRETCH) send_random($urandom_range(10, 90));
        settle_filter();
        write_reg(CFG_WIDTH, 11'd1);
        write_reg(CFG_HEIGHT, 11'd2047);
        repeat (LONG_STRETCH) send_random($urandom_range(10, 90));
        settle_filter();
        write_reg(CFG_HEIGHT, 11'($urandom_range(1, 6)));

        // Random part. Most phases are whole small frames with random content;
        // some change mode, height or a width no wider than the current one in the
        // middle of a frame, which may restart it.
        while (random_items < RANDOM_ITEMS)
        begin
            black_pct = $urandom_range(5, 95);
            if (!at_frame_start() && $urandom_range(0, 3) == 0)
            begin
                settle_filter();
                write_reg(CFG_MODE, 11'($urandom_range(0, 3)));
                if ($urandom_range(0, 1) == 1)
                begin
                    write_reg(CFG_HEIGHT, 11'($urandom_range(0, 8)));
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    write_reg(CFG_WIDTH, 11'($urandom_range(0, eff_size(wid_r, MAX_W))));
                end
            end
            else
            begin
                while (!at_frame_start())
                begin
                    send_random(black_pct);
                    random_items++;
                end
                settle_filter();
                write_reg(CFG_MODE, 11'($urandom_range(0, 3)));
                write_reg(CFG_WIDTH, 11'($urandom_range(0, 12)));
                write_reg(CFG_HEIGHT, 11'($urandom_range(0, 6)));
            end
            w = eff_size(wid_r, MAX_W);
            h = eff_size(hei_r, MAX_H);
            n = $urandom_range(1, 2 * w * h + 2);
            repeat (n) send_random(black_pct);
            random_items += n;
        end

        // Drain, then give any stray result time to show up before judging.
        settle_filter();
        if (mismatches == 0 && awaited_pixels.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
